// ===== hdl/ffa_pkg.sv =====
`default_nettype none
package ffa_pkg;

   localparam int TABLE_DEPTH_DEF  = 512;
   localparam int HEADER_BYTES_DEF = 4;

   localparam logic [15:0] HEAP_LIMIT_RESET  = 16'd10240;
   localparam logic [9:0]  CHUNK_LIMIT_RESET = 10'd510;

   localparam logic CSR_HEAP_LIMIT  = 1'b0;
   localparam logic CSR_CHUNK_LIMIT = 1'b1;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   typedef struct packed {
      logic        req_type;
      logic [15:0] alloc_bytes;
      logic [15:0] free_offset;
   } req_item_type;

   typedef struct packed {
      logic        ok;
      logic [15:0] payload_offset;
   } rsp_item_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_START,
      OP_RD,
      OP_A_NEXT,
      OP_A_TAKE,
      OP_SPLIT_SET,
      OP_SH_RD,
      OP_SH_WR,
      OP_SPLIT_LO,
      OP_SPLIT_HI,
      OP_GROW,
      OP_FAIL,
      OP_F_NEXT,
      OP_F_HIT,
      OP_M_EV,
      OP_M_FIN,
      OP_F_MISS
   } op_type;

   typedef struct packed {
      logic at_end;
      logic a_take;
      logic a_split;
      logic grow_ok;
      logic f_hit;
      logic sh_more;
   } status_type;

endpackage
`default_nettype wire

// ===== hdl/ffa_ctrl.sv =====
`default_nettype none
module ffa_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic              req_kind,
   input  ffa_pkg::status_type    status,
   output ffa_pkg::op_type        op,
   output logic                   busy
);
   import ffa_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_A_RD, S_A_EV, S_SH_CHK, S_SH_EV, S_HI,
      S_F_RD, S_F_EV, S_M_RD, S_M_EV
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;

   always_comb begin
      state_in = state_ff;
      op       = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op       = OP_START;
               state_in = (req_kind == REQ_FREE) ? S_F_RD : S_A_RD;
            end
         end
         S_A_RD: begin
            if (status.at_end) begin
               op       = status.grow_ok ? OP_GROW : OP_FAIL;
               state_in = S_IDLE;
            end else begin
               op       = OP_RD;
               state_in = S_A_EV;
            end
         end
         S_A_EV: begin
            if (status.a_take) begin
               op       = OP_A_TAKE;
               state_in = S_IDLE;
            end else if (status.a_split) begin
               op       = OP_SPLIT_SET;
               state_in = S_SH_CHK;
            end else begin
               op       = OP_A_NEXT;
               state_in = S_A_RD;
            end
         end
         S_SH_CHK: begin
            if (status.sh_more) begin
               op       = OP_SH_RD;
               state_in = S_SH_EV;
            end else begin
               op       = OP_SPLIT_LO;
               state_in = S_HI;
            end
         end
         S_SH_EV: begin
            op       = OP_SH_WR;
            state_in = S_SH_CHK;
         end
         S_HI: begin
            op       = OP_SPLIT_HI;
            state_in = S_IDLE;
         end
         S_F_RD: begin
            if (status.at_end) begin
               op       = OP_F_MISS;
               state_in = S_IDLE;
            end else begin
               op       = OP_RD;
               state_in = S_F_EV;
            end
         end
         S_F_EV: begin
            if (status.f_hit) begin
               op       = OP_F_HIT;
               state_in = S_M_RD;
            end else begin
               op       = OP_F_NEXT;
               state_in = S_F_RD;
            end
         end
         S_M_RD: begin
            if (status.at_end) begin
               op       = OP_M_FIN;
               state_in = S_IDLE;
            end else begin
               op       = OP_RD;
               state_in = S_M_EV;
            end
         end
         S_M_EV: begin
            op       = OP_M_EV;
            state_in = S_M_RD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != S_IDLE);
      end
   end

   assign busy = busy_ff;
endmodule
`default_nettype wire

// ===== hdl/ffa_datapath.sv =====
`default_nettype none
module ffa_datapath #(
   parameter int TABLE_DEPTH  = ffa_pkg::TABLE_DEPTH_DEF,
   parameter int HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  ffa_pkg::op_type           op,
   input  ffa_pkg::req_item_type     req_data,
   input  wire logic                 csr_we,
   input  wire logic                 csr_index,
   input  wire logic [15:0]          csr_wdata,
   output ffa_pkg::status_type       status,
   output logic                      rsp_valid,
   output ffa_pkg::rsp_item_type     rsp_data
);
   import ffa_pkg::*;

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [16:0] HDR = 17'(HEADER_BYTES);
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

   // each word holds capacity in the upper half, used bytes in the lower
   logic [31:0] mem [TABLE_DEPTH];

   logic [31:0]   q_ff;
   req_item_type  req_ff;
   logic [15:0]   heap_limit_ff;
   logic [9:0]    chunk_limit_ff;
   logic [CW-1:0] count_ff, idx_ff, tgt_ff, k_ff, m_ff;
   logic [15:0]   top_ff, acc_ff, sp_used_ff, sp_slack_ff, res_ff;
   logic [16:0]   pos_ff;
   logic          merging_ff;
   logic          rsp_valid_ff;
   rsp_item_type  rsp_ff;

   logic [15:0]   cap_q, used_q, slack;
   logic [16:0]   pos_next;
   logic          room, usable;
   logic          we;
   logic [AW-1:0] waddr, raddr;
   logic [31:0]   wdata;
   logic [CW-1:0] tgt_inc;

   assign cap_q    = q_ff[31:16];
   assign used_q   = q_ff[15:0];
   assign slack    = cap_q - used_q;
   assign pos_next = pos_ff + {1'b0, cap_q} + HDR;
   assign tgt_inc  = tgt_ff + CW'(1);
   assign room     = ({{(CW > 10 ? CW - 10 : 0){1'b0}}, chunk_limit_ff} >
                      {{(CW > 10 ? 0 : 10 - CW){1'b0}}, count_ff}) && (count_ff < DEPTH_C);
   assign usable   = (used_q <= cap_q) && (slack != 16'd0);

   always_comb begin
      status.at_end  = (idx_ff == count_ff);
      status.a_take  = usable && (used_q == 16'd0) && (slack >= req_ff.alloc_bytes);
      status.a_split = usable && ({1'b0, slack} >= {1'b0, req_ff.alloc_bytes} + HDR) && room;
      status.grow_ok = room && (({2'b0, top_ff} + {2'b0, req_ff.alloc_bytes} + {1'b0, HDR})
                       <= {2'b0, heap_limit_ff});
      status.f_hit   = ((pos_ff + HDR) == {1'b0, req_ff.free_offset});
      status.sh_more = ({1'b0, k_ff} > ({1'b0, tgt_ff} + (CW + 1)'(1)));
   end

   always_comb begin
      we    = 1'b0;
      waddr = idx_ff[AW-1:0];
      wdata = q_ff;
      raddr = (op == OP_SH_RD) ? AW'(k_ff - CW'(1)) : idx_ff[AW-1:0];
      case (op)
         OP_A_TAKE: begin
            we    = 1'b1;
            wdata = {cap_q, req_ff.alloc_bytes};
         end
         OP_SH_WR: begin
            we    = 1'b1;
            waddr = k_ff[AW-1:0];
         end
         OP_SPLIT_LO: begin
            we    = 1'b1;
            waddr = tgt_ff[AW-1:0];
            wdata = {sp_used_ff, sp_used_ff};
         end
         OP_SPLIT_HI: begin
            we    = 1'b1;
            waddr = tgt_inc[AW-1:0];
            wdata = {sp_slack_ff - HDR[15:0], req_ff.alloc_bytes};
         end
         OP_GROW: begin
            we    = 1'b1;
            waddr = count_ff[AW-1:0];
            wdata = {req_ff.alloc_bytes, req_ff.alloc_bytes};
         end
         OP_M_EV: begin
            // past the run of empty chunks, entries slide down over the merged ones
            we    = !(merging_ff && used_q == 16'd0);
            waddr = AW'(idx_ff - m_ff);
         end
         OP_M_FIN: begin
            we    = 1'b1;
            waddr = tgt_ff[AW-1:0];
            wdata = {acc_ff, 16'd0};
         end
         default: begin
            we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      q_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_limit_ff  <= HEAP_LIMIT_RESET;
         chunk_limit_ff <= CHUNK_LIMIT_RESET;
         count_ff       <= '0;
         top_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_HEAP_LIMIT) begin
               heap_limit_ff <= csr_wdata;
            end else begin
               chunk_limit_ff <= csr_wdata[9:0];
            end
         end
         rsp_valid_ff <= (op == OP_A_TAKE) || (op == OP_SPLIT_HI) || (op == OP_GROW) ||
                         (op == OP_FAIL) || (op == OP_M_FIN) || (op == OP_F_MISS);
         case (op)
            OP_SPLIT_HI: count_ff <= count_ff + CW'(1);
            OP_GROW: begin
               count_ff <= count_ff + CW'(1);
               top_ff   <= top_ff + req_ff.alloc_bytes + HDR[15:0];
            end
            OP_M_FIN: count_ff <= count_ff - m_ff;
            default: begin
               count_ff <= count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (op)
         OP_START: begin
            req_ff <= req_data;
            idx_ff <= '0;
            pos_ff <= '0;
         end
         OP_A_NEXT, OP_F_NEXT: begin
            pos_ff <= pos_next;
            idx_ff <= idx_ff + CW'(1);
         end
         OP_A_TAKE: begin
            rsp_ff <= '{ok: 1'b1, payload_offset: 16'(pos_ff + HDR)};
         end
         OP_SPLIT_SET: begin
            tgt_ff      <= idx_ff;
            k_ff        <= count_ff;
            sp_used_ff  <= used_q;
            sp_slack_ff <= slack;
            res_ff      <= 16'(pos_ff + HDR + {1'b0, used_q} + HDR);
         end
         OP_SH_WR: k_ff <= k_ff - CW'(1);
         OP_SPLIT_HI: rsp_ff <= '{ok: 1'b1, payload_offset: res_ff};
         OP_GROW: rsp_ff <= '{ok: 1'b1, payload_offset: top_ff + HDR[15:0]};
         OP_FAIL, OP_F_MISS: rsp_ff <= '{ok: 1'b0, payload_offset: 16'd0};
         OP_F_HIT: begin
            tgt_ff     <= idx_ff;
            acc_ff     <= cap_q;
            idx_ff     <= idx_ff + CW'(1);
            m_ff       <= '0;
            merging_ff <= 1'b1;
         end
         OP_M_EV: begin
            if (merging_ff && used_q == 16'd0) begin
               acc_ff <= acc_ff + cap_q + HDR[15:0];
               m_ff   <= m_ff + CW'(1);
            end else begin
               merging_ff <= 1'b0;
            end
            idx_ff <= idx_ff + CW'(1);
         end
         OP_M_FIN: rsp_ff <= '{ok: 1'b1, payload_offset: 16'd0};
         default: begin
            req_ff <= req_ff;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule
`default_nettype wire

// ===== hdl/first_fit_heap_allocator.sv =====
`default_nettype none
// channel   ports                               beat taken when
// request   start, busy, req_data               start & !busy
// response  rsp_valid, rsp_data                 rsp_valid (one cycle, no stall)
// csr       csr_we, csr_index, csr_wdata        csr_we
//
// an allocate walks the table chunk by chunk (registered read, then evaluate); a split
// then moves each later chunk up, entry by entry, and a free walks to the match, then
// compacts the rest entry by entry.
// synchronous reset clears the chunk count and heap top and sets the limits to their reset values;
// the table is not cleared. the response appears the cycle busy drops and cannot be held off.
module first_fit_heap_allocator #(
   parameter int TABLE_DEPTH  = ffa_pkg::TABLE_DEPTH_DEF,
   parameter int HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  ffa_pkg::req_item_type   req_data,
   output logic                    rsp_valid,
   output ffa_pkg::rsp_item_type   rsp_data,
   input  wire logic               csr_we,
   input  wire logic               csr_index,
   input  wire logic [15:0]        csr_wdata
);
   import ffa_pkg::*;

   op_type     op;
   status_type status;

   ffa_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_data.req_type),
      .status   (status),
      .op       (op),
      .busy     (busy)
   );

   ffa_datapath #(
      .TABLE_DEPTH  (TABLE_DEPTH),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .op        (op),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTH
   a_done_has_rsp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid) else $error("busy dropped without a response");
   a_rsp_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("response while still busy");
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.ok) |-> (rsp_data.payload_offset == 16'd0))
      else $error("failed response with nonzero offset");
`endif
endmodule
`default_nettype wire
